// ===== rtl/cfrt_pkg.sv =====
// ----------------------------------------------------------------------------
// cfrt_pkg
// Shared types and constants of the chunk frame reassembly tracker.
// ----------------------------------------------------------------------------
`default_nettype none
package cfrt_pkg;
  localparam int unsigned MaxFrames   = 8;
  localparam int unsigned MaxChunks   = 128;
  localparam int unsigned HeaderBytes = 10;
  localparam int unsigned SlotW       = $clog2(MaxFrames);
  localparam int unsigned CntW        = $clog2(MaxFrames + 1);
  localparam int unsigned ChunkW      = $clog2(MaxChunks);
  localparam int unsigned UniqW       = $clog2(MaxChunks + 1);

  typedef enum logic [1:0] {
    EvInvalid  = 2'd0,
    EvRecorded = 2'd1,
    EvDup      = 2'd2,
    EvComplete = 2'd3
  } event_e;

  typedef enum logic {
    CfgTimeout = 1'b0,
    CfgLimit   = 1'b1
  } cfg_idx_e;

  // One table entry as held in the entry memory.
  typedef struct packed {
    logic [15:0]          frame_id;
    logic [15:0]          expected;
    logic [31:0]          last_seen;
    logic [MaxChunks-1:0] chunk_map;
    logic [UniqW-1:0]     unique_cnt;
  } entry_t;

  // Counter increments requested by the control unit.
  typedef struct packed {
    logic        packet;
    logic [15:0] bytes;
    logic        invalid;
    logic        dup;
    logic        complete;
    logic        incomplete;
    logic [16:0] missing;
    logic        evicted;
    logic        peak_chk;
  } stat_upd_t;
endpackage
`default_nettype wire

// ===== rtl/cfrt_stats.sv =====
// ----------------------------------------------------------------------------
// cfrt_stats
// Saturating statistics counters.
// ----------------------------------------------------------------------------
`default_nettype none
module cfrt_stats (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire cfrt_pkg::stat_upd_t       upd_i,
  input  wire logic [cfrt_pkg::CntW-1:0] in_flight_i,
  output logic [31:0]                    packet_o,
  output logic [47:0]                    byte_o,
  output logic [31:0]                    invalid_o,
  output logic [31:0]                    dup_o,
  output logic [31:0]                    complete_o,
  output logic [31:0]                    incomplete_o,
  output logic [31:0]                    missing_o,
  output logic [31:0]                    evicted_o,
  output logic [cfrt_pkg::CntW-1:0]      peak_o
);
  import cfrt_pkg::*;

  function automatic logic [31:0] sat32(logic [31:0] a, logic [16:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {16'd0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  logic [48:0] byte_sum;
  assign byte_sum = {1'b0, byte_o} + {33'd0, upd_i.bytes};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      packet_o <= '0; byte_o <= '0; invalid_o <= '0; dup_o <= '0;
      complete_o <= '0; incomplete_o <= '0; missing_o <= '0; evicted_o <= '0;
      peak_o <= '0;
    end else begin
      packet_o     <= sat32(packet_o, {16'd0, upd_i.packet});
      byte_o       <= byte_sum[48] ? '1 : byte_sum[47:0];
      invalid_o    <= sat32(invalid_o, {16'd0, upd_i.invalid});
      dup_o        <= sat32(dup_o, {16'd0, upd_i.dup});
      complete_o   <= sat32(complete_o, {16'd0, upd_i.complete});
      incomplete_o <= sat32(incomplete_o, {16'd0, upd_i.incomplete});
      missing_o    <= sat32(missing_o, upd_i.missing);
      evicted_o    <= sat32(evicted_o, {16'd0, upd_i.evicted});
      if (upd_i.peak_chk && in_flight_i > peak_o) begin
        peak_o <= in_flight_i;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/chunk_frame_reassembly_tracker_core.sv =====
// ----------------------------------------------------------------------------
// chunk_frame_reassembly_tracker_core
// Tracks reassembly of chunked frames over an eight-entry table.
// ----------------------------------------------------------------------------
// One chunk header is handled at a time. A valid header walks the entry
// memory once, one slot per cycle (timeout retire and lookup). It then does a
// read-modify-write of the hit or newly allocated slot. An eviction on a full
// table adds an oldest search and the evict, and each eviction down to the
// limit adds an oldest search, evict and recheck. An invalid header goes
// straight to the output. The entry memory, read one slot a cycle, sets the
// length of the walk.
// The result sits in an output register and the next transaction is taken
// once it has been handed over.
`default_nettype none
module chunk_frame_reassembly_tracker_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] packet_length_i,
  input  wire logic [15:0] frame_id_i,
  input  wire logic [15:0] chunk_index_i,
  input  wire logic [15:0] total_chunks_i,
  input  wire logic [31:0] now_ms_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       event_res_o,
  output logic [31:0]      packet_total_o,
  output logic [47:0]      byte_total_o,
  output logic [31:0]      invalid_total_o,
  output logic [31:0]      duplicate_total_o,
  output logic [31:0]      completed_total_o,
  output logic [31:0]      incomplete_total_o,
  output logic [31:0]      missing_total_o,
  output logic [31:0]      evicted_total_o,
  output logic [3:0]       in_flight_o,
  output logic [3:0]       peak_in_flight_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  import cfrt_pkg::*;

  typedef enum logic [7:0] {
    StIdle   = 8'b0000_0001,
    StScan   = 8'b0000_0010, // retire timed-out slots, look up frame id
    StDecide = 8'b0000_0100,
    StRmw    = 8'b0000_1000, // read selected slot, then write it back
    StOld    = 8'b0001_0000, // search oldest valid slot
    StEvict  = 8'b0010_0000,
    StStat   = 8'b0100_0000,
    StOut    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Entry memory: synchronous read, one slot per cycle.
  entry_t mem [MaxFrames];
  entry_t rd_q;
  logic   we;
  logic [SlotW-1:0] waddr, raddr;
  entry_t wdata;
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  logic [MaxFrames-1:0] valid_q, valid_d;
  logic [30:0] timeout_q;
  logic [3:0]  limit_q;

  // Captured transaction.
  logic [15:0] fid_q, idx_q;
  logic [31:0] now_q;
  logic [16:0] exp_q;

  logic [SlotW:0]   ptr_q, ptr_d;   // read pointer, one beyond the data in rd_q
  logic [SlotW-1:0] hit_q, hit_d, slot_q, slot_d, old_q, old_d;
  logic             hitv_q, hitv_d, oldv_q, oldv_d, alloc_q, alloc_d;
  logic [31:0]      oage_q, oage_d;
  logic [15:0]      ofid_q, ofid_d;
  logic [1:0]       ev_q, ev_d;
  stat_upd_t        upd;
  logic [CntW-1:0]  nvalid;
  logic [SlotW-1:0] rslot;
  logic [31:0]      age;
  logic [16:0]      limit;
  logic [16:0]      miss;
  logic [SlotW-1:0] free_slot;
  logic             free_any;

  assign rslot = ptr_q[SlotW-1:0] - 1'b1;
  assign age   = now_q - rd_q.last_seen;
  assign limit = (limit_q == 4'd0 || limit_q > 4'(MaxFrames)) ? 17'(MaxFrames) :
                 {13'd0, limit_q};
  assign miss  = ({1'b0, rd_q.expected} > 17'(rd_q.unique_cnt)) ?
                 {1'b0, rd_q.expected} - 17'(rd_q.unique_cnt) : '0;

  always_comb begin
    nvalid = '0;
    for (int i = 0; i < MaxFrames; i++) nvalid = nvalid + CntW'(valid_q[i]);
    free_any  = 1'b0;
    free_slot = '0;
    for (int i = MaxFrames - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_any = 1'b1; free_slot = SlotW'(i);
      end
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign cfg_ready_o = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= '0; limit_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgTimeout: timeout_q <= cfg_data_i[30:0];
        CfgLimit:   limit_q   <= cfg_data_i[3:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      fid_q <= frame_id_i; idx_q <= chunk_index_i; now_q <= now_ms_i;
      exp_q <= ({1'b0, chunk_index_i} + 17'd1 > {1'b0, total_chunks_i}) ?
               {1'b0, chunk_index_i} + 17'd1 : {1'b0, total_chunks_i};
    end
  end

  always_comb begin
    state_d = state_q; ptr_d = ptr_q; valid_d = valid_q;
    hit_d = hit_q; hitv_d = hitv_q; slot_d = slot_q; alloc_d = alloc_q;
    old_d = old_q; oldv_d = oldv_q; oage_d = oage_q; ofid_d = ofid_q; ev_d = ev_q;
    upd = '0; we = 1'b0; waddr = slot_q; wdata = rd_q; raddr = ptr_q[SlotW-1:0];
    unique case (state_q)
      StIdle: begin
        ptr_d = '0; raddr = '0;
        if (in_valid_i) begin
          upd.packet = 1'b1; upd.bytes = packet_length_i;
          hitv_d = 1'b0; ev_d = EvInvalid;
          if (packet_length_i < 16'(HeaderBytes) || chunk_index_i >= 16'(MaxChunks)) begin
            upd.invalid = 1'b1; state_d = StOut;
          end else begin
            ptr_d = (SlotW+1)'(1); state_d = StScan;
          end
        end
      end
      StScan: begin
        // rd_q holds slot ptr_q-1
        if (valid_q[rslot]) begin
          if (timeout_q != '0 && age > {1'b0, timeout_q}) begin
            valid_d[rslot] = 1'b0; upd.incomplete = 1'b1; upd.missing = miss;
          end else if (rd_q.frame_id == fid_q && !hitv_q) begin
            hitv_d = 1'b1; hit_d = rslot;
          end
        end
        if (ptr_q == (SlotW+1)'(MaxFrames)) state_d = StDecide;
        else ptr_d = ptr_q + 1'b1;
      end
      StDecide: begin
        alloc_d = 1'b0;
        if (hitv_q) begin
          slot_d = hit_q; raddr = hit_q; state_d = StRmw;
        end else if (free_any) begin
          slot_d = free_slot; alloc_d = 1'b1; raddr = free_slot; state_d = StRmw;
        end else if (exp_q <= 17'd1) begin
          upd.complete = 1'b1; ev_d = EvComplete; state_d = StStat;
        end else begin
          // full table: find oldest, new frame competes with age 0
          alloc_d = 1'b1; oldv_d = 1'b0; raddr = '0; ptr_d = (SlotW+1)'(1);
          state_d = StOld;
        end
      end
      StRmw: begin
        wdata = rd_q;
        if (alloc_q) begin
          wdata.frame_id = fid_q; wdata.expected = exp_q[15:0];
          wdata.chunk_map = '0; wdata.unique_cnt = '0;
          valid_d[slot_q] = 1'b1;
        end else if (exp_q > {1'b0, rd_q.expected}) begin
          wdata.expected = exp_q[15:0];
        end
        wdata.last_seen = now_q;
        if (wdata.chunk_map[idx_q[ChunkW-1:0]]) begin
          upd.dup = 1'b1; ev_d = EvDup;
        end else begin
          wdata.chunk_map[idx_q[ChunkW-1:0]] = 1'b1;
          wdata.unique_cnt = wdata.unique_cnt + 1'b1;
          ev_d = EvRecorded;
        end
        if (17'(wdata.unique_cnt) >= {1'b0, wdata.expected}) begin
          upd.complete = 1'b1; ev_d = EvComplete; valid_d[slot_q] = 1'b0;
        end
        we = 1'b1; waddr = slot_q;
        state_d = StStat;
      end
      StOld: begin
        if (valid_q[rslot]) begin
          if (!oldv_q || age > oage_q || (age == oage_q && rd_q.frame_id < ofid_q)) begin
            oldv_d = 1'b1; old_d = rslot; oage_d = age; ofid_d = rd_q.frame_id;
          end
        end
        if (ptr_q == (SlotW+1)'(MaxFrames)) begin
          raddr = old_d; state_d = StEvict;
        end else ptr_d = ptr_q + 1'b1;
      end
      StEvict: begin
        // rd_q holds the oldest slot
        if (alloc_q && oage_q == '0 && fid_q < ofid_q) begin
          upd.incomplete = 1'b1; upd.evicted = 1'b1; upd.missing = exp_q - 17'd1;
          ev_d = EvRecorded; alloc_d = 1'b0; state_d = StStat;
        end else begin
          upd.incomplete = 1'b1; upd.evicted = 1'b1; upd.missing = miss;
          valid_d[old_q] = 1'b0;
          if (alloc_q) begin
            slot_d = old_q; raddr = old_q; state_d = StRmw;
          end else state_d = StStat;
        end
      end
      StStat: begin
        // shrink to limit, else finish
        if (17'(nvalid) > limit) begin
          alloc_d = 1'b0; oldv_d = 1'b0; raddr = '0; ptr_d = (SlotW+1)'(1);
          state_d = StOld;
        end else begin
          upd.peak_chk = 1'b1; state_d = StOut;
        end
      end
      StOut: begin
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; valid_q <= '0; ptr_q <= '0; hitv_q <= 1'b0;
      oldv_q <= 1'b0; alloc_q <= 1'b0; ev_q <= EvInvalid;
    end else begin
      state_q <= state_d; valid_q <= valid_d; ptr_q <= ptr_d; hitv_q <= hitv_d;
      oldv_q <= oldv_d; alloc_q <= alloc_d; ev_q <= ev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q <= hit_d; slot_q <= slot_d; old_q <= old_d; oage_q <= oage_d;
    ofid_q <= ofid_d;
  end

  logic [CntW-1:0] peak;
  cfrt_stats u_stats (
    .clk_i, .rst_ni, .upd_i(upd), .in_flight_i(nvalid),
    .packet_o(packet_total_o), .byte_o(byte_total_o), .invalid_o(invalid_total_o),
    .dup_o(duplicate_total_o), .complete_o(completed_total_o),
    .incomplete_o(incomplete_total_o), .missing_o(missing_total_o),
    .evicted_o(evicted_total_o), .peak_o(peak)
  );

  assign event_res_o      = ev_q;
  assign in_flight_o      = 4'(nvalid);
  assign peak_in_flight_o = 4'(peak);

  // An invalid header leaves the table alone, so only valid ones end within the limit.
  a_out_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut && ev_q != EvInvalid) |-> 17'(nvalid) <= limit)
    else $error("table holds more frames than the limit");
  a_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StOut |-> peak >= nvalid)
    else $error("peak below in-flight count");
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> in_ready_o)
    else $error("configuration taken while busy");
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the chunk frame reassembly tracker: a queue-fed
// driver, a monitor that checks every result against a behavioural model of
// the frame table and counters, and several phases of configuration and idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import cfrt_pkg::*;

  typedef struct packed {
    logic [15:0] len;
    logic [15:0] fid;
    logic [15:0] idx;
    logic [15:0] tot;
    logic [31:0] now;
  } hdr_t;

  typedef struct packed {
    event_e      ev;
    logic [31:0] pkt;
    logic [47:0] bytes;
    logic [31:0] inv;
    logic [31:0] dup;
    logic [31:0] comp;
    logic [31:0] incomp;
    logic [31:0] miss;
    logic [31:0] evict;
    logic [3:0]  nflight;
    logic [3:0]  peak;
  } stats_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Drive every input to a known value from time zero.
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] packet_length_i = '0;
  logic [15:0] frame_id_i = '0;
  logic [15:0] chunk_index_i = '0;
  logic [15:0] total_chunks_i = '0;
  logic [31:0] now_ms_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  event_res_o;
  logic [31:0] packet_total_o, invalid_total_o, duplicate_total_o, completed_total_o;
  logic [31:0] incomplete_total_o, missing_total_o, evicted_total_o;
  logic [47:0] byte_total_o;
  logic [3:0]  in_flight_o, peak_in_flight_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  chunk_frame_reassembly_tracker_core i_dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Frame table model
  // ---------------------------------------------------------------------------
  logic                 tbl_valid [MaxFrames];
  logic [15:0]          tbl_fid   [MaxFrames];
  logic [15:0]          tbl_exp   [MaxFrames];
  logic [31:0]          tbl_seen  [MaxFrames];
  logic [MaxChunks-1:0] tbl_map   [MaxFrames];
  int unsigned          tbl_uniq  [MaxFrames];
  logic [30:0]          timeout_ms = '0;
  logic [3:0]           frame_limit = '0;
  stats_t               tally = '0;

  function automatic logic [31:0] sat32(logic [31:0] a, longint unsigned b);
    longint unsigned s;
    s = longint'(a) + b;
    return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void count_incomplete(int unsigned expv, int unsigned uniq);
    tally.incomp = sat32(tally.incomp, 1);
    if (expv > uniq) tally.miss = sat32(tally.miss, expv - uniq);
  endfunction

  function automatic int unsigned frames_held();
    int unsigned n;
    n = 0;
    for (int s = 0; s < MaxFrames; s++) if (tbl_valid[s]) n++;
    return n;
  endfunction

  function automatic int oldest_frame(logic [31:0] now);
    int best;
    logic [31:0] age, bage;
    best = -1;
    for (int s = 0; s < MaxFrames; s++) begin
      if (!tbl_valid[s]) continue;
      if (best < 0) begin
        best = s;
        continue;
      end
      age  = now - tbl_seen[s];
      bage = now - tbl_seen[best];
      if (age > bage || (age == bage && tbl_fid[s] < tbl_fid[best])) best = s;
    end
    return best;
  endfunction

  function automatic void evict_frame(int s);
    count_incomplete(tbl_exp[s], tbl_uniq[s]);
    tally.evict = sat32(tally.evict, 1);
    tbl_valid[s] = 1'b0;
  endfunction

  function automatic void claim_frame(int s, hdr_t h, int unsigned expv);
    tbl_valid[s] = 1'b1;
    tbl_fid[s]   = h.fid;
    tbl_exp[s]   = expv[15:0];
    tbl_seen[s]  = h.now;
    tbl_map[s]   = '0;
    tbl_uniq[s]  = 0;
  endfunction

  function automatic stats_t track_chunk(hdr_t h);
    int slot, old;
    int unsigned expv, lim, n;
    longint unsigned b;
    tally.ev  = EvInvalid;
    tally.pkt = sat32(tally.pkt, 1);
    b = longint'(tally.bytes) + h.len;
    tally.bytes = (b > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : b[47:0];
    if (h.len < HeaderBytes || h.idx >= MaxChunks) begin
      tally.inv = sat32(tally.inv, 1);
    end else begin
      if (timeout_ms != 0) begin
        for (int s = 0; s < MaxFrames; s++)
          if (tbl_valid[s] && (h.now - tbl_seen[s]) > {1'b0, timeout_ms}) begin
            count_incomplete(tbl_exp[s], tbl_uniq[s]);
            tbl_valid[s] = 1'b0;
          end
      end
      expv = (h.idx + 1 > h.tot) ? h.idx + 1 : h.tot;
      lim  = (frame_limit == 0 || frame_limit > MaxFrames) ? MaxFrames : frame_limit;
      slot = -1;
      for (int s = 0; s < MaxFrames; s++)
        if (slot < 0 && tbl_valid[s] && tbl_fid[s] == h.fid) slot = s;
      if (slot >= 0) begin
        tbl_seen[slot] = h.now;
        if (expv > tbl_exp[slot]) tbl_exp[slot] = expv[15:0];
      end else begin
        for (int s = 0; s < MaxFrames; s++) if (slot < 0 && !tbl_valid[s]) slot = s;
        if (slot >= 0) begin
          claim_frame(slot, h, expv);
        end else if (expv <= 1) begin
          tally.comp = sat32(tally.comp, 1);
          tally.ev = EvComplete;
        end else begin
          old = oldest_frame(h.now);
          tally.ev = EvRecorded;
          if (h.now == tbl_seen[old] && h.fid < tbl_fid[old]) begin
            // New frame loses the tie: drop it at once.
            count_incomplete(expv, 1);
            tally.evict = sat32(tally.evict, 1);
          end else begin
            evict_frame(old);
            slot = old;
            claim_frame(slot, h, expv);
          end
        end
      end
      if (slot >= 0 && tbl_valid[slot]) begin
        if (tbl_map[slot][h.idx]) begin
          tally.dup = sat32(tally.dup, 1);
          tally.ev = EvDup;
        end else begin
          tbl_map[slot][h.idx] = 1'b1;
          tbl_uniq[slot]++;
          tally.ev = EvRecorded;
        end
        if (tbl_uniq[slot] >= tbl_exp[slot]) begin
          tally.comp = sat32(tally.comp, 1);
          tbl_valid[slot] = 1'b0;
          tally.ev = EvComplete;
        end
      end
      while (frames_held() > lim) evict_frame(oldest_frame(h.now));
      n = frames_held();
      if (n > tally.peak) tally.peak = n[3:0];
    end
    tally.nflight = 4'(frames_held());
    return tally;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver, monitor and stall control
  // ---------------------------------------------------------------------------
  hdr_t   pending_hdrs[$];
  stats_t expected_stats[$];
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     hold_off_cycles = 0;
  int     mismatches = 0;
  int     checked = 0;

  always @(posedge clk_i) begin
    if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) expected_stats.push_back(track_chunk({packet_length_i, frame_id_i,
          chunk_index_i, total_chunks_i, now_ms_i}));
      if (pending_hdrs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        hdr_t h;
        h = pending_hdrs.pop_front();
        in_valid_i      <= 1'b1;
        packet_length_i <= h.len;
        frame_id_i      <= h.fid;
        chunk_index_i   <= h.idx;
        total_chunks_i  <= h.tot;
        now_ms_i        <= h.now;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Long receiver hold-off is counted here so the block fills and stalls.
  always @(posedge clk_i) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      stats_t got, want;
      got = {event_e'(event_res_o), packet_total_o, byte_total_o, invalid_total_o,
             duplicate_total_o, completed_total_o, incomplete_total_o, missing_total_o,
             evicted_total_o, in_flight_o, peak_in_flight_o};
      checked++;
      if (expected_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_stats.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch #%0d\n  exp %p\n  got %p", checked, want, got);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  logic [31:0] clock_ms = 32'd1000;

  function automatic void queue_hdr(int len, int fid, int idx, int tot, logic [31:0] now);
    hdr_t h;
    h.len = 16'(len); h.fid = 16'(fid); h.idx = 16'(idx); h.tot = 16'(tot); h.now = now;
    pending_hdrs.push_back(h);
  endfunction

  // Well-formed frames with random chunk order, interleaved, plus some noise.
  function automatic void queue_random(int n, int fid_span);
    int fid, tot;
    for (int k = 0; k < n; k++) begin
      clock_ms += $urandom_range(3) == 0 ? $urandom_range(400) : $urandom_range(4);
      fid = $urandom_range(fid_span);
      tot = 1 + $urandom_range(5);
      case ($urandom_range(19))
        0: queue_hdr($urandom_range(9), $urandom, $urandom, $urandom, clock_ms);
        1: queue_hdr($urandom, $urandom, $urandom, $urandom, $urandom);
        2: queue_hdr(10 + $urandom_range(65525), fid, MaxChunks + $urandom_range(65407),
                     tot, clock_ms);
        3: queue_hdr(10 + $urandom_range(65525), fid, $urandom_range(MaxChunks - 1),
                     $urandom, clock_ms);
        default: queue_hdr(10 + $urandom_range(1500), fid, $urandom_range(tot - 1), tot,
                           clock_ms);
      endcase
    end
  endfunction

  // Sample at the falling edge so the driver's updates have settled.
  task automatic drain();
    while (pending_hdrs.size() > 0 || in_valid_i || expected_stats.size() > 0)
      @(negedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CfgTimeout) timeout_ms = data[30:0];
    else frame_limit = data[3:0];
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    for (int s = 0; s < MaxFrames; s++) begin
      tbl_valid[s] = 1'b0; tbl_fid[s] = '0; tbl_exp[s] = '0;
      tbl_seen[s] = '0; tbl_map[s] = '0; tbl_uniq[s] = 0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: extremes, short packets, bad index, duplicates, single chunk,
    // full table with tie on a new frame, limit lowered, timeout.
    queue_hdr(0, 16'hFFFF, 0, 0, 0);
    queue_hdr(9, 0, 0, 1, 1);
    queue_hdr(65535, 1, MaxChunks, 2, 2);
    queue_hdr(65535, 2, 65535, 65535, 3);
    queue_hdr(10, 3, 0, 1, 4);
    queue_hdr(10, 4, MaxChunks - 1, 0, 5);
    queue_hdr(10, 4, MaxChunks - 1, 0, 5);
    queue_hdr(10, 5, 0, 2, 6);
    queue_hdr(10, 5, 1, 2, 7);
    for (int f = 0; f < 8; f++) queue_hdr(100, 100 + f, 0, 3, 32'hFFFF_FFF0);
    queue_hdr(100, 50, 0, 3, 32'hFFFF_FFF0);
    queue_hdr(100, 200, 1, 3, 32'hFFFF_FFF0);
    queue_hdr(100, 7, 0, 1, 32'hFFFF_FFF1);
    queue_hdr(100, 300, 0, 4, 32'h0000_0005);
    drain();

    write_reg(CfgLimit, 2);
    queue_hdr(20, 10, 0, 3, 10);
    queue_hdr(20, 11, 0, 3, 11);
    queue_hdr(20, 12, 0, 3, 11);
    drain();
    write_reg(CfgTimeout, 32'h7FFF_FFFF);
    write_reg(CfgLimit, 15);
    queue_hdr(20, 13, 0, 3, 32'h8000_0100);
    drain();
    write_reg(CfgTimeout, 1);
    queue_hdr(20, 14, 0, 3, 32'h8000_0103);
    drain();

    // Random phases: settings and idling patterns vary.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        3: begin send_idle_pct = 8;  recv_stall_pct = 8;  end
        4: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_off_cycles = 800; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      write_reg(CfgTimeout, ph == 5 ? 0 : $urandom_range(600));
      write_reg(CfgLimit, ph == 0 ? 0 : ph == 1 ? 1 : $urandom_range(15));
      queue_random(150, ph[0] ? 12 : 65535 >> (ph * 3));
      drain();
    end

    $display("checked %0d results over directed frames and six random phases", checked);
    $display("covered idling mixes, a long receiver hold-off and limits from 1 to full");
    if (mismatches == 0 && expected_stats.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("%0d mismatches, %0d results left", mismatches, expected_stats.size());
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("tb NOT OK");
    $finish;
  end
endmodule
`default_nettype wire
